// ===== rtl/core/utsc_pkg.sv =====
// Package for the UTF-8 text sample classifier: byte classes, the queue
// record passed from front to back, constants and the byte classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utsc_pkg;

  localparam int unsigned UTSC_FIFO_DEPTH    = 4;
  localparam logic [15:0] SAMPLE_LIMIT_RESET = 16'd256;

  localparam logic [7:0] MASK_TOP1  = 8'h80;
  localparam logic [7:0] MASK_TOP2  = 8'hc0;
  localparam logic [7:0] MASK_TOP3  = 8'he0;
  localparam logic [7:0] MASK_TOP4  = 8'hf0;
  localparam logic [7:0] MASK_TOP5  = 8'hf8;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] PAT_LEAD2  = 8'hc0;
  localparam logic [7:0] PAT_LEAD3  = 8'he0;
  localparam logic [7:0] PAT_LEAD4  = 8'hf0;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7e;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  typedef enum logic [2:0] {
    CLS_ASCII_OK,
    CLS_ASCII_BAD,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_INVALID
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t cls;
    logic      present;
    logic      last;
  } utsc_item_t;

  function automatic byte_cls_t classify_byte(input logic [7:0] b);
    byte_cls_t cls;
    cls = CLS_INVALID;
    if ((b & MASK_TOP1) == 8'h00) begin
      if ((b >= CHAR_SPACE && b <= CHAR_TILDE) ||
          b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR) begin
        cls = CLS_ASCII_OK;
      end else begin
        cls = CLS_ASCII_BAD;
      end
    end else if ((b & MASK_TOP2) == PAT_CONT) begin
      cls = CLS_CONT;
    end else if ((b & MASK_TOP3) == PAT_LEAD2) begin
      cls = CLS_LEAD2;
    end else if ((b & MASK_TOP4) == PAT_LEAD3) begin
      cls = CLS_LEAD3;
    end else if ((b & MASK_TOP5) == PAT_LEAD4) begin
      cls = CLS_LEAD4;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utsc_if.sv =====
// Handshake interfaces for the classifier's byte channel and verdict channel.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface utsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_item;

  modport source (output valid, output data_byte, output byte_present,
                  output last_item, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input last_item, output ready);
endinterface

interface utsc_out_if;
  logic valid;
  logic ready;
  logic is_text;
  logic was_empty;

  modport source (output valid, output is_text, output was_empty, input ready);
  modport sink   (input valid, input is_text, input was_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/utsc_front.sv =====
// Front end: accepts byte words, classifies each byte and holds the record
// in a register stage until the queue takes it. Depends on utsc_pkg, utsc_if.
`timescale 1ns / 1ps
`default_nettype none

module utsc_front (
  input  wire                 clk,
  input  wire                 rst_n,
  utsc_in_if.sink             in_ch,
  output logic                push_valid,
  input  wire                 push_ready,
  output utsc_pkg::utsc_item_t push_item
);
  import utsc_pkg::*;

  logic       stg_valid_r;
  logic       stg_valid_nxt;
  utsc_item_t stg_item_r;
  logic       in_acc;

  assign in_ch.ready = !stg_valid_r || push_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign push_valid  = stg_valid_r;
  assign push_item   = stg_item_r;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_acc) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_valid_r && push_ready) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_item_r.cls     <= classify_byte(in_ch.data_byte);
      stg_item_r.present <= in_ch.byte_present;
      stg_item_r.last    <= in_ch.last_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utsc_fifo.sv =====
// Short queue of classified records between the front and back ends.
// Depends on utsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utsc_fifo #(
  parameter int unsigned Depth = utsc_pkg::UTSC_FIFO_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  utsc_pkg::utsc_item_t push_item,
  output logic                 pop_valid,
  input  wire                  pop_ready,
  output utsc_pkg::utsc_item_t pop_item
);
  import utsc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  utsc_item_t          store_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utsc_back.sv =====
// Back end: applies the sample limit, tracks open sequences and failure,
// and registers the verdict for the result channel. Depends on utsc_pkg, utsc_if.
`timescale 1ns / 1ps
`default_nettype none

module utsc_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire [15:0]           sample_limit,
  input  wire                  pop_valid,
  output logic                 pop_ready,
  input  utsc_pkg::utsc_item_t pop_item,
  utsc_out_if.source           out_ch
);
  import utsc_pkg::*;

  logic [1:0]  pending_r, pending_nxt;
  logic        failed_r, failed_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_text_r, out_empty_r;
  logic        do_pop, take, slot_free;
  logic        empty_now, text_now;

  // A record that carries no verdict may pass while the output word waits.
  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop_ready = !pop_item.last || slot_free;
  assign do_pop    = pop_valid && pop_ready;
  assign take      = pop_item.present && (seen_r < sample_limit);

  always_comb begin
    pending_nxt = pending_r;
    failed_nxt  = failed_r;
    seen_nxt    = seen_r;
    if (take) begin
      seen_nxt = seen_r + 16'd1;
      if (pending_r != 2'd0) begin
        if (pop_item.cls == CLS_CONT) begin
          pending_nxt = pending_r - 2'd1;
        end else begin
          failed_nxt  = 1'b1;
          pending_nxt = 2'd0;
        end
      end else begin
        case (pop_item.cls)
          CLS_ASCII_OK: ;
          CLS_LEAD2:    pending_nxt = 2'd1;
          CLS_LEAD3:    pending_nxt = 2'd2;
          CLS_LEAD4:    pending_nxt = 2'd3;
          default:      failed_nxt  = 1'b1;
        endcase
      end
    end
    empty_now = (seen_nxt == 16'd0);
    text_now  = !empty_now && !failed_nxt && (pending_nxt == 2'd0);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (do_pop && pop_item.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 2'd0;
      failed_r    <= 1'b0;
      seen_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (do_pop) begin
        if (pop_item.last) begin
          pending_r <= 2'd0;
          failed_r  <= 1'b0;
          seen_r    <= 16'd0;
        end else begin
          pending_r <= pending_nxt;
          failed_r  <= failed_nxt;
          seen_r    <= seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_item.last) begin
      out_text_r  <= text_now;
      out_empty_r <= empty_now;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.is_text   = out_text_r;
  assign out_ch.was_empty = out_empty_r;

endmodule

`default_nettype wire

// ===== rtl/core/utsc_text_sample_classifier_top.sv =====
// An end-of-file word passes the front register stage and the queue, and the back end
// registers its verdict. One byte word per cycle is accepted unless the queue or output stalls.
// The queue between front and back lets either side stall while the other keeps going.
// Reset (rst_n, synchronous) empties the pipeline, clears the per-file state and
// restores the sample limit to 256.
// Depends on utsc_pkg, utsc_if, utsc_front, utsc_fifo, utsc_back.
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_sample_classifier #(
  parameter int unsigned FifoDepth = utsc_pkg::UTSC_FIFO_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  utsc_in_if.sink    in_chan,
  utsc_out_if.source out_chan,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [15:0] cfg_sample_limit
);
  import utsc_pkg::*;

  logic [15:0] sample_limit_r;
  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;
  utsc_item_t  push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_limit_r <= SAMPLE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sample_limit_r <= cfg_sample_limit;
    end
  end

  utsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  utsc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  utsc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_limit (sample_limit_r),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .out_ch       (out_chan)
  );

endmodule

`default_nettype wire

// ===== rtl/core/utsc_checker.sv =====
// Port-level checks for the classifier, bound to the top level.
// Depends on utf8_text_sample_classifier and utsc_if.
`timescale 1ns / 1ps
`default_nettype none

module utsc_checker (
  input wire clk,
  input wire rst_n,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire is_text,
  input wire was_empty
);

  // Reset empties the pipeline, so no verdict word is left over.
  a_no_word_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict word present after reset");

  // The input side is free straight after reset.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // An empty sample can never be judged as text.
  a_empty_not_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(is_text && was_empty))
    else $error("empty sample reported as text");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(is_text) && $stable(was_empty))
    else $error("stalled verdict word changed");

endmodule

bind utf8_text_sample_classifier utsc_checker u_utsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .is_text   (out_chan.is_text),
  .was_empty (out_chan.was_empty)
);

`default_nettype wire

// ===== tb/utf8_text_sample_classifier_tb.sv =====
// Self-checking testbench for utf8_text_sample_classifier: drives files byte by byte,
// predicts each text/binary verdict and compares it with the block's output.
// Depends on utsc_pkg, utsc_if and the classifier RTL.
`timescale 1ns / 1ps

module utf8_text_sample_classifier_tb;
  import utsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef struct packed {
    bit is_text;
    bit was_empty;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_sample_limit;

  utsc_in_if  in_if ();
  utsc_out_if out_if ();

  utf8_text_sample_classifier dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_chan          (in_if),
    .out_chan         (out_if),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_sample_limit (cfg_sample_limit)
  );

  // Shadow of the classifier state, advanced on every accepted word.
  logic [1:0]  pend_cont;
  bit          sample_bad;
  logic [15:0] bytes_taken;
  logic [15:0] limit_shadow;

  verdict_t verdict_q[$];

  int unsigned src_idle_pct;
  int unsigned rcv_stall_pct;
  bit          hold_off;
  int unsigned cycles;
  int unsigned fail_count;
  int unsigned shown_count;
  int unsigned words_sent;
  int unsigned files_sent;
  int unsigned verdicts_checked;
  int unsigned text_verdicts;
  int unsigned limits_written;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, verdict_q.size());
    $display("** utf8_text_sample_classifier: FAILED **");
    $finish;
  end

  function automatic bit printable_byte(input logic [7:0] b);
    return (b >= CHAR_SPACE && b <= CHAR_TILDE) ||
           b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR;
  endfunction

  // Advances the shadow state by one word; returns 1 when the word ends a file.
  function automatic bit predict_verdict(input logic [7:0] b, input bit present,
                                         input bit last, output verdict_t v);
    v = '0;
    if (present && bytes_taken < limit_shadow) begin
      bytes_taken = bytes_taken + 16'd1;
      if (pend_cont != 2'd0) begin
        if ((b & MASK_TOP2) == PAT_CONT) begin
          pend_cont = pend_cont - 2'd1;
        end else begin
          sample_bad = 1'b1;
          pend_cont  = 2'd0;
        end
      end else if ((b & MASK_TOP1) == 8'h00) begin
        if (!printable_byte(b)) sample_bad = 1'b1;
      end else if ((b & MASK_TOP3) == PAT_LEAD2) begin
        pend_cont = 2'd1;
      end else if ((b & MASK_TOP4) == PAT_LEAD3) begin
        pend_cont = 2'd2;
      end else if ((b & MASK_TOP5) == PAT_LEAD4) begin
        pend_cont = 2'd3;
      end else begin
        sample_bad = 1'b1;
      end
    end
    if (!last) return 1'b0;
    v.was_empty = (bytes_taken == 16'd0);
    v.is_text   = !v.was_empty && !sample_bad && pend_cont == 2'd0;
    pend_cont   = 2'd0;
    sample_bad  = 1'b0;
    bytes_taken = 16'd0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] lead_byte(input int n_cont);
    case (n_cont)
      1:       return PAT_LEAD2 | 8'($urandom_range(0, 31));
      2:       return PAT_LEAD3 | 8'($urandom_range(0, 15));
      default: return PAT_LEAD4 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return PAT_CONT | 8'($urandom_range(0, 63));
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (shown_count < MAX_SHOWN) begin
      shown_count++;
      $display("[%0t] %s", $time, msg);
    end
  endtask

  // Receiver: randomly stalls, and checks each accepted verdict against the oldest prediction.
  initial begin
    verdict_t exp_v;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (verdict_q.size() == 0) begin
          note_failure($sformatf("unexpected verdict is_text=%0b was_empty=%0b",
                                 out_if.is_text, out_if.was_empty));
        end else begin
          exp_v = verdict_q.pop_front();
          verdicts_checked++;
          if (exp_v.is_text) text_verdicts++;
          if (out_if.is_text !== exp_v.is_text || out_if.was_empty !== exp_v.was_empty) begin
            note_failure($sformatf(
              "verdict %0d: expected is_text=%0b was_empty=%0b, got is_text=%0b was_empty=%0b",
              verdicts_checked, exp_v.is_text, exp_v.was_empty,
              out_if.is_text, out_if.was_empty));
          end
        end
      end
      out_if.ready <= !hold_off && ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  task automatic send_word(input logic [7:0] b, input bit present, input bit last);
    verdict_t v;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= b;
    in_if.byte_present <= present;
    in_if.last_item    <= last;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    if (predict_verdict(b, present, last, v)) begin
      verdict_q.push_back(v);
      files_sent++;
    end
    if (present || last) words_sent++;
  endtask

  // Sends the bytes of one file; the end is either flagged on the final byte or
  // carried by a separate end marker with no byte.
  task automatic send_file(input logic [7:0] body[$], input bit end_marker);
    for (int i = 0; i < body.size(); i++) begin
      if ($urandom_range(0, 99) < 3) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(body[i], 1'b1, !end_marker && i == body.size() - 1);
    end
    if (end_marker || body.size() == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_random_file(input int max_chars, input int noise_pct);
    logic [7:0] body[$];
    int n_chars;
    int roll;
    int n_cont;
    n_chars = $urandom_range(0, max_chars);
    for (int c = 0; c < n_chars; c++) begin
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
        case ($urandom_range(0, 3))
          0: body.push_back(8'($urandom));
          1: body.push_back(cont_byte());
          2: body.push_back(MASK_TOP5 | 8'($urandom_range(0, 7)));
          default: begin
            // A lead byte short of its continuation bytes.
            n_cont = $urandom_range(1, 3);
            body.push_back(lead_byte(n_cont));
            repeat ($urandom_range(0, n_cont - 1)) body.push_back(cont_byte());
          end
        endcase
      end else if (roll < 60) begin
        body.push_back(8'($urandom_range(32, 126)));
      end else if (roll < 66) begin
        case ($urandom_range(0, 2))
          0:       body.push_back(CHAR_TAB);
          1:       body.push_back(CHAR_LF);
          default: body.push_back(CHAR_CR);
        endcase
      end else begin
        n_cont = $urandom_range(1, 3);
        body.push_back(lead_byte(n_cont));
        repeat (n_cont) body.push_back(cont_byte());
      end
    end
    send_file(body, 1'($urandom_range(0, 1)));
  endtask

  // The limit is only changed once the pipeline has drained; words that give no
  // verdict may still be in flight, so the task keeps waiting after the last verdict.
  task automatic write_sample_limit(input logic [15:0] value);
    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_sample_limit <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid        <= 1'b0;
    cfg_sample_limit <= 16'($urandom);
    limit_shadow = value;
    limits_written++;
  endtask

  task automatic test_default_limit();
    logic [7:0] body[$];
    // Exactly 256 printable bytes are examined; the control byte after them is ignored.
    repeat (256) body.push_back(8'($urandom_range(32, 126)));
    body.push_back(8'h00);
    send_file(body, 1'b0);
  endtask

  task automatic test_single_bytes();
    logic [7:0] none[$];
    send_file(none, 1'b1);
    send_file('{CHAR_SPACE, CHAR_TILDE}, 1'b1);
    send_file('{CHAR_TAB, CHAR_LF, CHAR_CR}, 1'b0);
    send_file('{8'h00}, 1'b0);
    send_file('{8'h7f}, 1'b0);
    send_file('{8'hff}, 1'b0);
  endtask

  task automatic test_sequences();
    send_file('{8'hc2, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98, 8'h80}, 1'b1);
  endtask

  task automatic test_broken_sequences();
    send_word(8'hff, 1'b0, 1'b0);
    send_file('{8'he2, 8'h82}, 1'b1);
    send_file('{8'h80, 8'h41}, 1'b0);
    send_file('{8'hc3, 8'h41}, 1'b0);
  endtask

  task automatic test_limit_edges();
    write_sample_limit(16'd2);
    send_file('{8'h41, 8'h42, 8'hff}, 1'b0);
    send_file('{8'h41, 8'hc2, 8'ha9}, 1'b0);
    write_sample_limit(16'd0);
    send_file('{8'h41}, 1'b0);
    write_sample_limit(16'd1);
    send_file('{CHAR_LF, 8'h80}, 1'b1);
  endtask

  // The receiver holds off for a long stretch while short files keep coming,
  // so the queue fills and the input stalls.
  task automatic test_backpressure();
    write_sample_limit(16'd8);
    src_idle_pct = 0;
    rcv_stall_pct <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (40) send_random_file(3, 10);
  endtask

  task automatic test_random_phase(input int src_pct, input int rcv_pct,
                                   input logic [15:0] limit, input int n_words);
    int unsigned start;
    write_sample_limit(limit);
    src_idle_pct = src_pct;
    rcv_stall_pct <= rcv_pct;
    start = words_sent;
    while (words_sent - start < n_words) send_random_file(24, 20);
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= 8'h00;
    in_if.byte_present <= 1'b0;
    in_if.last_item    <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_sample_limit   <= 16'h0000;
    hold_off           <= 1'b0;
    rcv_stall_pct      <= 0;
    src_idle_pct     = 0;
    pend_cont        = 2'd0;
    sample_bad       = 1'b0;
    bytes_taken      = 16'd0;
    limit_shadow     = SAMPLE_LIMIT_RESET;
    fail_count       = 0;
    shown_count      = 0;
    words_sent       = 0;
    files_sent       = 0;
    verdicts_checked = 0;
    text_verdicts    = 0;
    limits_written   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_default_limit();
    test_single_bytes();
    test_sequences();
    test_broken_sequences();
    test_limit_edges();
    test_backpressure();
    test_random_phase(0, 0, 16'hffff, 150);
    test_random_phase(64, 0, 16'($urandom_range(1, 12)), 150);
    test_random_phase(0, 64, SAMPLE_LIMIT_RESET, 150);
    test_random_phase(17, 17, 16'($urandom_range(1, 40)), 150);

    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d words in %0d files under %0d sample limit writes.",
             words_sent, files_sent, limits_written);
    $display("Checked %0d verdicts (%0d text), %0d failures.",
             verdicts_checked, text_verdicts, fail_count);
    if (fail_count == 0) begin
      $display("** utf8_text_sample_classifier: PASSED **");
    end else begin
      $display("** utf8_text_sample_classifier: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/utsc_pkg.sv
rtl/core/utsc_if.sv
rtl/core/utsc_front.sv
rtl/core/utsc_fifo.sv
rtl/core/utsc_back.sv
rtl/core/utsc_text_sample_classifier_top.sv
rtl/core/utsc_checker.sv
tb/utf8_text_sample_classifier_tb.sv
